FILE: sv/ntm_pkg.sv
// Shared types and constants for the nearest timestamp match block.
package ntm_pkg;

    localparam int SEQ_W   = 31;
    localparam int STAMP_W = 48;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [SEQ_W-1:0]   imu_sequence;
        logic [STAMP_W-1:0] imu_timestamp;
        logic [SEQ_W-1:0]   camera_sequence;
        logic [STAMP_W-1:0] camera_timestamp;
    } t_in_item;

    typedef struct packed {
        logic               matched;
        logic [SEQ_W-1:0]   frame_sequence;
        logic [SEQ_W-1:0]   nearest_sequence;
        logic [STAMP_W-1:0] time_gap;
    } t_out_item;

endpackage

FILE: sv/nearest_timestamp_match_core.sv
// Nearest timestamp match: entry table in two memories, binary search over them.
//
// Clear and load transfers keep busy low, so a new transfer may follow at once. A query
// holds busy through S rounds of the probe and compare states, a last probe state and
// the first gap state, then, unless the first entry at or after the query time is entry
// zero or no entry lies at or after the query time, a second gap state and the pick
// state; S is the number of search probes, at most ceil(log2(n + 1)) for n loaded
// entries (up to 11 for a full table of 1024). Each probe costs one memory read and one
// compare, since the tables are memories with one write port, one read port and
// registered read data. A query on an empty table does not raise busy. The result is
// presented with o_strobe for one cycle right after busy drops; it cannot be held off, so
// the receiver must take it in that cycle. Loads beyond TABLE_DEPTH entries are dropped.
module nearest_timestamp_match_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ntm_pkg::t_in_item i_item,
    output logic              o_strobe,
    output ntm_pkg::t_out_item o_result
);
    import ntm_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_GAP_A,
        S_GAP_B,
        S_PICK
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [IW-1:0]      r_mid;
    logic [SEQ_W-1:0]   r_cam_seq;
    logic [STAMP_W-1:0] r_cam_ts;
    logic [STAMP_W-1:0] r_gap;
    logic [SEQ_W-1:0]   r_seq;
    logic [STAMP_W-1:0] r_gap_prev;
    logic [SEQ_W-1:0]   r_seq_prev;
    logic               r_strobe;
    t_out_item          r_out;

    logic [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];
    logic [SEQ_W-1:0]   seq_mem   [TABLE_DEPTH];
    logic [STAMP_W-1:0] r_rd_stamp;
    logic [SEQ_W-1:0]   r_rd_seq;

    logic               w_accept;
    logic               w_wr_en;
    logic [IW-1:0]      w_rd_addr;
    logic [CW:0]        w_sum;
    logic [IW-1:0]      w_mid;
    logic               w_more;
    logic [CW-1:0]      w_fetch;
    logic [CW-1:0]      w_prev;
    logic [STAMP_W-1:0] w_gap;

    function automatic logic [STAMP_W-1:0] abs_diff(input logic [STAMP_W-1:0] a,
                                                    input logic [STAMP_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    assign w_accept = start && (r_state == S_IDLE);
    assign w_wr_en  = w_accept && (i_item.action == ACT_LOAD)
                      && (r_count < CW'(TABLE_DEPTH));
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi} - (CW+1)'(1);
    assign w_mid    = w_sum[IW:1];
    assign w_more   = (r_lo < r_hi);
    assign w_fetch  = (r_lo == r_count) ? (r_count - CW'(1)) : r_lo;
    assign w_prev   = r_lo - CW'(1);
    assign w_gap    = abs_diff(r_rd_stamp, r_cam_ts);

    always_comb begin
        case (r_state)
            S_PROBE: begin
                w_rd_addr = w_more ? w_mid : w_fetch[IW-1:0];
            end
            S_GAP_A: begin
                w_rd_addr = w_prev[IW-1:0];
            end
            default: begin
                w_rd_addr = w_mid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            stamp_mem[r_count[IW-1:0]] <= i_item.imu_timestamp;
            seq_mem[r_count[IW-1:0]]   <= i_item.imu_sequence;
        end
        r_rd_stamp <= stamp_mem[w_rd_addr];
        r_rd_seq   <= seq_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cam_seq <= i_item.camera_sequence;
                        r_cam_ts  <= i_item.camera_timestamp;
                        r_lo      <= '0;
                        r_hi      <= r_count;
                        case (i_item.action)
                            ACT_CLEAR: begin
                                r_count <= '0;
                            end
                            ACT_LOAD: begin
                                if (w_wr_en) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            ACT_QUERY: begin
                                if (r_count == '0) begin
                                    r_out.matched          <= 1'b0;
                                    r_out.frame_sequence   <= i_item.camera_sequence;
                                    r_out.nearest_sequence <= '0;
                                    r_out.time_gap         <= '0;
                                    r_strobe               <= 1'b1;
                                end else begin
                                    r_state <= S_PROBE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PROBE: begin
                    if (w_more) begin
                        r_mid   <= w_mid;
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_GAP_A;
                    end
                end
                S_CMP: begin
                    if (r_rd_stamp >= r_cam_ts) begin
                        r_hi <= CW'(r_mid);
                    end else begin
                        r_lo <= CW'(r_mid) + CW'(1);
                    end
                    r_state <= S_PROBE;
                end
                S_GAP_A: begin
                    r_gap <= w_gap;
                    r_seq <= r_rd_seq;
                    if ((r_lo != r_count) && (r_lo != '0)) begin
                        r_state <= S_GAP_B;
                    end else begin
                        r_out.matched          <= 1'b1;
                        r_out.frame_sequence   <= r_cam_seq;
                        r_out.nearest_sequence <= r_rd_seq;
                        r_out.time_gap         <= w_gap;
                        r_strobe               <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                S_GAP_B: begin
                    r_gap_prev <= w_gap;
                    r_seq_prev <= r_rd_seq;
                    r_state    <= S_PICK;
                end
                S_PICK: begin
                    r_out.matched        <= 1'b1;
                    r_out.frame_sequence <= r_cam_seq;
                    if (r_gap_prev <= r_gap) begin
                        r_out.nearest_sequence <= r_seq_prev;
                        r_out.time_gap         <= r_gap_prev;
                    end else begin
                        r_out.nearest_sequence <= r_seq;
                        r_out.time_gap         <= r_gap;
                    end
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

FILE: tb/tb_nearest_timestamp_match_core.sv
// Self-checking testbench for the nearest timestamp match core: table loads, clears and queries.
module tb_nearest_timestamp_match_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ntm_pkg::*;

    localparam int                 DEPTH        = 1024;
    localparam int                 RANDOM_ITEMS = 550;
    localparam logic [1:0]         ACT_SPARE    = 2'd3;
    localparam logic [STAMP_W-1:0] STAMP_MAX    = '1;
    localparam logic [SEQ_W-1:0]   SEQ_MAX      = '1;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_item  = '0;
    logic      o_strobe;
    t_out_item o_result;

    t_in_item           pending_items[$];
    t_out_item          expected_results[$];
    logic [STAMP_W-1:0] planned_stamps[$];
    logic [STAMP_W-1:0] stamp_tbl [DEPTH];
    logic [SEQ_W-1:0]   seq_tbl   [DEPTH];
    int                 entry_cnt  = 0;
    int                 mismatches = 0;
    int                 planned    = 0;
    int                 burst_left = 0;
    int                 gap_left   = 0;
    logic               xfer_done  = 1'b0;

    always #10 i_clk = ~i_clk;

    nearest_timestamp_match_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns mismatch: %s", $realtime, what);
    endtask

    function automatic logic [STAMP_W-1:0] stamp_dist(input logic [STAMP_W-1:0] a,
                                                      input logic [STAMP_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Advance the table copy by one transfer; queue the result a query produces.
    task automatic apply_item(input t_in_item it);
        int                 lo;
        int                 hi;
        int                 mid;
        int                 found;
        int                 pick;
        logic [STAMP_W-1:0] gap;
        logic [STAMP_W-1:0] prev_gap;
        t_out_item          r;
        case (it.action)
            ACT_CLEAR: begin
                entry_cnt = 0;
            end
            ACT_LOAD: begin
                if (entry_cnt < DEPTH) begin
                    stamp_tbl[entry_cnt] = it.imu_timestamp;
                    seq_tbl[entry_cnt]   = it.imu_sequence;
                    entry_cnt++;
                end
            end
            ACT_QUERY: begin
                r = '0;
                r.frame_sequence = it.camera_sequence;
                if (entry_cnt > 0) begin
                    lo    = 0;
                    hi    = entry_cnt - 1;
                    found = -1;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        if (stamp_tbl[mid] >= it.camera_timestamp) begin
                            found = mid;
                            hi    = mid - 1;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                    pick = (found < 0) ? entry_cnt - 1 : found;
                    gap  = stamp_dist(stamp_tbl[pick], it.camera_timestamp);
                    if (found >= 1) begin
                        prev_gap = stamp_dist(stamp_tbl[found - 1], it.camera_timestamp);
                        if (prev_gap <= gap) begin
                            pick = found - 1;
                            gap  = prev_gap;
                        end
                    end
                    r.matched          = 1'b1;
                    r.nearest_sequence = seq_tbl[pick];
                    r.time_gap         = gap;
                end
                expected_results = {expected_results, r};
            end
            default: ;
        endcase
    endtask

    // Monitor: check results, then track accepted transfers.
    always @(posedge i_clk) begin
        t_out_item want;
        xfer_done <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result frame %0h",
                                              o_result.frame_sequence));
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.matched !== want.matched)
                        report_mismatch($sformatf("matched got %0b expected %0b",
                                                  o_result.matched, want.matched));
                    if (o_result.frame_sequence !== want.frame_sequence)
                        report_mismatch($sformatf("frame_sequence got %0h expected %0h",
                                                  o_result.frame_sequence,
                                                  want.frame_sequence));
                    if (o_result.nearest_sequence !== want.nearest_sequence)
                        report_mismatch($sformatf("nearest_sequence got %0h expected %0h",
                                                  o_result.nearest_sequence,
                                                  want.nearest_sequence));
                    if (o_result.time_gap !== want.time_gap)
                        report_mismatch($sformatf("time_gap got %0h expected %0h",
                                                  o_result.time_gap, want.time_gap));
                end
            end
            if (start && !busy)
                apply_item(i_item);
        end
    end

    // Driver: bursts of transfers separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || xfer_done)) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic logic [SEQ_W-1:0] rand_seq();
        logic [31:0] v;
        v = $urandom();
        return v[SEQ_W-1:0];
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[STAMP_W-1:0];
    endfunction

    function automatic logic [STAMP_W-1:0] sat_add(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
        return (STAMP_MAX - a < b) ? STAMP_MAX : a + b;
    endfunction

    task automatic push_item(input logic [1:0] act, input logic [SEQ_W-1:0] iseq,
                             input logic [STAMP_W-1:0] its, input logic [SEQ_W-1:0] cseq,
                             input logic [STAMP_W-1:0] cts);
        t_in_item it;
        it.action           = act;
        it.imu_sequence     = iseq;
        it.imu_timestamp    = its;
        it.camera_sequence  = cseq;
        it.camera_timestamp = cts;
        pending_items = {pending_items, it};
    endtask

    task automatic push_clear();
        push_item(ACT_CLEAR, rand_seq(), rand_stamp(), rand_seq(), rand_stamp());
    endtask

    task automatic push_load(input logic [SEQ_W-1:0] seq, input logic [STAMP_W-1:0] ts);
        push_item(ACT_LOAD, seq, ts, rand_seq(), rand_stamp());
    endtask

    task automatic push_query(input logic [SEQ_W-1:0] seq, input logic [STAMP_W-1:0] ts);
        push_item(ACT_QUERY, rand_seq(), rand_stamp(), seq, ts);
    endtask

    // Pick a query time, mostly near the planned entries: on, beside, between or outside them.
    function automatic logic [STAMP_W-1:0] probe_stamp();
        int                 n;
        int                 k;
        logic [STAMP_W-1:0] a;
        logic [STAMP_W-1:0] b;
        n = planned_stamps.size();
        if (n == 0)
            return rand_stamp();
        k = $urandom_range(0, n - 1);
        a = planned_stamps[k];
        case ($urandom_range(0, 7))
            0: return a;
            1: return sat_add(a, STAMP_W'(1));
            2: return (a == 0) ? a : a - 1;
            3: begin
                if (k + 1 >= n)
                    return a;
                b = planned_stamps[k + 1];
                return (b >= a) ? a + ((b - a) >> 1) : a;
            end
            4: return '0;
            5: return STAMP_MAX;
            6: return sat_add(planned_stamps[0], rand_stamp() >> $urandom_range(8, 40));
            default: return rand_stamp();
        endcase
    endfunction

    // One well-formed sequence: clear, ordered loads, then queries with a few late loads.
    task automatic plan_session(input int n_loads, input int n_queries);
        logic [STAMP_W-1:0] ts;
        int                 shift;
        planned_stamps.delete();
        push_clear();
        case ($urandom_range(0, 2))
            0: ts = '0;
            1: ts = rand_stamp() >> $urandom_range(0, 47);
            default: ts = STAMP_MAX - $urandom_range(0, 5000);
        endcase
        case ($urandom_range(0, 3))
            0: shift = 46;
            1: shift = 38;
            2: shift = 20;
            default: shift = 8;
        endcase
        for (int i = 0; i < n_loads; i++) begin
            if (i > 0)
                ts = sat_add(ts, rand_stamp() >> shift);
            push_load(rand_seq(), ts);
            planned_stamps = {planned_stamps, ts};
        end
        for (int j = 0; j < n_queries; j++) begin
            if ($urandom_range(0, 5) == 0) begin
                ts = sat_add(ts, rand_stamp() >> shift);
                push_load(rand_seq(), ts);
                planned_stamps = {planned_stamps, ts};
                planned++;
            end
            push_query(rand_seq(), probe_stamp());
        end
        planned += 1 + n_loads + n_queries;
    endtask

    initial begin
        int   saved;
        int   n;
        logic [1:0] act;
        logic filled;

        // directed part
        push_query(SEQ_MAX, STAMP_MAX);
        push_item(ACT_SPARE, rand_seq(), rand_stamp(), rand_seq(), rand_stamp());
        push_load('0, 48'd0);
        push_load(SEQ_MAX, 48'd100);
        push_load(31'd5, 48'd100);
        push_load(31'd6, 48'd300);
        push_load(31'd7, STAMP_MAX);
        push_query(31'd1, 48'd0);
        push_query(31'd2, 48'd100);
        push_query(31'd3, 48'd200);
        push_query(31'd4, 48'd50);
        push_query('0, STAMP_MAX);
        push_query(31'd8, STAMP_MAX - 1);
        push_clear();
        push_query(31'd9, 48'd77);
        push_load(31'd1, 48'd10);
        push_query(31'd10, 48'd5);
        push_query(31'd11, 48'd20);
        push_load(31'd2, 48'd3);
        push_query(31'd12, 48'd4);
        push_item(ACT_SPARE, rand_seq(), rand_stamp(), rand_seq(), rand_stamp());
        push_clear();

        // random part
        filled = 1'b0;
        while (planned < RANDOM_ITEMS) begin
            if (!filled && planned >= RANDOM_ITEMS / 2) begin
                saved = planned;
                plan_session(DEPTH + 6, 12);
                planned = saved;
                filled  = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    act = 2'($urandom_range(0, 3));
                    push_item(act, rand_seq(), rand_stamp(), rand_seq(), rand_stamp());
                    if (act != ACT_SPARE)
                        planned++;
                end
            end else begin
                case ($urandom_range(0, 5))
                    0: n = 0;
                    1: n = $urandom_range(21, 60);
                    default: n = $urandom_range(1, 20);
                endcase
                plan_session(n, $urandom_range(1, 10));
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_items.size() != 0 || start || busy || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatches == 0) begin
            $display("PASS nearest_timestamp_match_core");
        end else begin
            $display("FAIL nearest_timestamp_match_core");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL nearest_timestamp_match_core");
        $finish;
    end

endmodule
